/* rtl/was_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// was_pkg
// shared constants and types for the windowed average and slope block
// ----------------------------------------------------------------------------
package was_pkg;
	localparam int DEFAULT_DEPTH = 8;
	localparam int MS_PER_S = 1000;
	localparam int DIV_W = 64;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	typedef struct packed {
		logic        start;
		logic        neg;
		logic [63:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] quot;
	} div_rsp_t;
endpackage
`default_nettype wire

/* rtl/windowed_average_and_slope.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_average_and_slope
// ring of the last DEPTH samples with gaps; reports mean value and mean slope
// ----------------------------------------------------------------------------
// channel  direction  signals
// in       sink       in_valid, in_stall, sample_value, time_ms, restart
// out      source     out_valid, out_stall, average_value .. sample_count
//
// one beat in, one beat out; no new beat is taken until the result leaves
// each beat runs, from accept to the next accept, a read and an accumulate per
// stored sample, a divide per slope (count-1 slopes) and one per mean, then the
// output state and the idle state; a zero gap skips its divide and a single
// sample skips the slope mean
// reset clears write slot, count, previous time and handshake state
// a stalled result holds until taken; in_stall stays high meanwhile
// ----------------------------------------------------------------------------
module windowed_average_and_slope #(
	parameter int DEPTH = was_pkg::DEFAULT_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] sample_value,
	input  wire logic [31:0]        time_ms,
	input  wire logic               restart,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      average_value,
	output logic signed [31:0]      average_slope,
	output logic                    slope_valid,
	output logic                    slope_saturated,
	output logic [3:0]              sample_count
);
	import was_pkg::*;

	localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_READ  = 7'b0000010,
		ST_ACC   = 7'b0000100,
		ST_SDIV  = 7'b0001000,
		ST_MEANV = 7'b0010000,
		ST_MEANS = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [31:0] sample_mem [DEPTH];
	logic [31:0] gap_mem [DEPTH];

	logic [SW-1:0] wslot_q;
	logic [CW-1:0] count_q;
	logic [31:0]   prev_time_q;
	logic [CW-1:0] idx_q;       // position from oldest
	logic [SW-1:0] rd_slot_q;
	logic signed [31:0] rd_val_q;
	logic signed [31:0] prev_val_q;
	logic [31:0]   rd_gap_q;
	logic signed [63:0] sum_q;
	logic signed [63:0] slope_sum_q;
	logic          sat_q;
	logic          div_wait_q;
	logic signed [63:0] dv_q;

	div_req_t dreq;
	div_rsp_t drsp;

	was_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// next slot after s, wrapping at DEPTH
	function automatic logic [SW-1:0] nxt(input logic [SW-1:0] s);
		if ({1'b0, s} == (SW+1)'(DEPTH - 1)) return '0;
		return s + SW'(1);
	endfunction

	logic accept;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	logic [CW-1:0] new_count;
	logic [SW-1:0] base_slot;
	logic [SW-1:0] oldest;
	logic [SW:0]   osum;
	always_comb begin
		base_slot = restart ? '0 : wslot_q;
		new_count = restart ? CW'(1) :
			((count_q == CW'(DEPTH)) ? count_q : count_q + CW'(1));
		// oldest = slot after write - count, modulo DEPTH
		osum = {1'b0, nxt(base_slot)} + (SW+1)'(DEPTH) - (SW+1)'(new_count);
		oldest = (osum >= (SW+1)'(DEPTH)) ? SW'(osum - (SW+1)'(DEPTH)) : SW'(osum);
	end

	// slope numerator dv*1000 as 1024 - 16 - 8
	logic signed [63:0] dv_k;
	assign dv_k = (dv_q <<< 10) - (dv_q <<< 4) - (dv_q <<< 3);

	logic signed [63:0] q_s;
	assign q_s = signed'(drsp.quot);

	always_comb begin
		dreq = '0;
		if (state_q == ST_SDIV && !div_wait_q && rd_gap_q != 32'd0) begin
			dreq.start = 1'b1;
			dreq.neg   = dv_k[63];
			dreq.num   = dv_k[63] ? 64'(-dv_k) : dv_k;
			dreq.den   = rd_gap_q;
		end else if (state_q == ST_MEANV && !div_wait_q) begin
			dreq.start = 1'b1;
			dreq.neg   = sum_q[63];
			dreq.num   = sum_q[63] ? 64'(-sum_q) : sum_q;
			dreq.den   = 32'(count_q);
		end else if (state_q == ST_MEANS && !div_wait_q) begin
			dreq.start = 1'b1;
			dreq.neg   = slope_sum_q[63];
			dreq.num   = slope_sum_q[63] ? 64'(-slope_sum_q) : slope_sum_q;
			dreq.den   = 32'(count_q - CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_mem[base_slot] <= sample_value;
			gap_mem[base_slot] <= (restart || count_q == '0) ? 32'd0
				: time_ms - prev_time_q;
		end
		rd_val_q <= signed'(sample_mem[rd_slot_q]);
		rd_gap_q <= gap_mem[rd_slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			wslot_q       <= '0;
			count_q       <= '0;
			prev_time_q   <= '0;
			div_wait_q    <= 1'b0;
			idx_q         <= '0;
			rd_slot_q     <= '0;
			sum_q         <= '0;
			slope_sum_q   <= '0;
			sat_q         <= 1'b0;
			prev_val_q    <= '0;
			dv_q          <= '0;
			average_value <= '0;
			average_slope <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wslot_q     <= nxt(base_slot);
						count_q     <= new_count;
						prev_time_q <= time_ms;
						rd_slot_q   <= oldest;
						idx_q       <= '0;
						sum_q       <= '0;
						slope_sum_q <= '0;
						sat_q       <= 1'b0;
						state_q     <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_ACC; // ring read data lands
				ST_ACC: begin
					sum_q <= sum_q + 64'(rd_val_q);
					prev_val_q <= rd_val_q;
					dv_q <= 64'(rd_val_q) - 64'(prev_val_q);
					rd_slot_q <= nxt(rd_slot_q);
					idx_q <= idx_q + CW'(1);
					if (idx_q != '0) state_q <= ST_SDIV;
					else if (count_q == CW'(1)) state_q <= ST_MEANV;
					else state_q <= ST_READ;
				end
				ST_SDIV: begin
					// rd_gap_q only holds this pair's gap on entry, before it reloads from the next slot
					if (div_wait_q) begin
						if (drsp.done) begin
							div_wait_q <= 1'b0;
							if (q_s > 64'(Q_MAX)) begin
								sat_q <= 1'b1;
								slope_sum_q <= slope_sum_q + 64'(Q_MAX);
							end else if (q_s < 64'(Q_MIN)) begin
								sat_q <= 1'b1;
								slope_sum_q <= slope_sum_q + 64'(Q_MIN);
							end else begin
								slope_sum_q <= slope_sum_q + q_s;
							end
							state_q <= (idx_q == count_q) ? ST_MEANV : ST_READ;
						end
					end else if (rd_gap_q == 32'd0) begin
						sat_q <= 1'b1;
						slope_sum_q <= slope_sum_q + (dv_q > 0 ? 64'(Q_MAX)
							: (dv_q < 0 ? 64'(Q_MIN) : 64'sd0));
						state_q <= (idx_q == count_q) ? ST_MEANV : ST_READ;
					end else begin
						div_wait_q <= 1'b1;
					end
				end
				ST_MEANV: begin
					if (!div_wait_q) div_wait_q <= 1'b1;
					else if (drsp.done) begin
						div_wait_q <= 1'b0;
						average_value <= q_s[31:0];
						if (count_q >= CW'(2)) state_q <= ST_MEANS;
						else begin
							average_slope <= '0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_MEANS: begin
					if (!div_wait_q) div_wait_q <= 1'b1;
					else if (drsp.done) begin
						div_wait_q <= 1'b0;
						average_slope <= q_s[31:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign slope_valid     = (count_q >= CW'(2));
	assign slope_saturated = slope_valid && sat_q;
	assign sample_count    = 4'(count_q);
endmodule
`default_nettype wire

/* rtl/was_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// was_divider
// shared restoring divider, one quotient bit per cycle, sign applied at end
// ----------------------------------------------------------------------------
module was_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire was_pkg::div_req_t req,
	output was_pkg::div_rsp_t      rsp
);
	import was_pkg::*;

	logic [63:0] quot_q;
	logic [32:0] rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic [31:0] den_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], quot_q[63]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.num;
			rem_q  <= '0;
			den_q  <= req.den;
			neg_q  <= req.neg;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q  <= trial;
				quot_q <= {quot_q[62:0], 1'b1};
			end else begin
				rem_q  <= shifted;
				quot_q <= {quot_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? (~quot_q + 64'd1) : quot_q;
endmodule
`default_nettype wire

/* sim/tb_windowed_average_and_slope.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_average_and_slope
// drives timestamped samples into the window block and checks every result
// beat against a local model of the ring, the mean and the mean slope
// ----------------------------------------------------------------------------

typedef struct packed {
	logic signed [31:0] average_value;
	logic signed [31:0] average_slope;
	logic               slope_valid;
	logic               slope_saturated;
	logic [3:0]         sample_count;
} window_result_t;

class window_scoreboard;
	localparam int DEPTH = was_pkg::DEFAULT_DEPTH;
	logic signed [31:0] values[DEPTH];
	logic [31:0]        gaps[DEPTH];
	int unsigned        slot;
	int unsigned        filled;
	logic [31:0]        last_time;
	window_result_t     pending[$];
	int                 mismatches;

	function new();
		slot = 0;
		filled = 0;
		last_time = 0;
		mismatches = 0;
	endfunction

	// update the window with one accepted sample and queue the expected result
	function void note_sample(logic signed [31:0] value, logic [31:0] now, logic restart);
		longint sum, slope_sum, dv, slope;
		int unsigned oldest, a, b;
		window_result_t r;
		if (restart) begin
			slot = 0;
			filled = 0;
		end
		values[slot] = value;
		gaps[slot] = (filled == 0) ? 32'd0 : now - last_time;
		last_time = now;
		slot = (slot + 1) % DEPTH;
		if (filled < DEPTH)
			filled++;
		oldest = (slot + DEPTH - filled) % DEPTH;
		sum = 0;
		for (int i = 0; i < filled; i++)
			sum += longint'(values[(oldest + i) % DEPTH]);
		r = '0;
		r.average_value = 32'(sum / longint'(filled));
		r.sample_count = 4'(filled);
		if (filled >= 2) begin
			slope_sum = 0;
			r.slope_valid = 1'b1;
			for (int i = 0; i + 1 < filled; i++) begin
				a = (oldest + i) % DEPTH;
				b = (a + 1) % DEPTH;
				dv = longint'(values[b]) - longint'(values[a]);
				if (gaps[b] == 0) begin
					r.slope_saturated = 1'b1;
					slope = (dv > 0) ? longint'(was_pkg::Q_MAX) :
						(dv < 0) ? longint'(was_pkg::Q_MIN) : 0;
				end else begin
					slope = (dv * was_pkg::MS_PER_S) / longint'({32'd0, gaps[b]});
					if (slope > longint'(was_pkg::Q_MAX)) begin
						slope = was_pkg::Q_MAX;
						r.slope_saturated = 1'b1;
					end else if (slope < longint'(was_pkg::Q_MIN)) begin
						slope = was_pkg::Q_MIN;
						r.slope_saturated = 1'b1;
					end
				end
				slope_sum += slope;
			end
			r.average_slope = 32'(slope_sum / longint'(filled - 1));
		end
		pending.push_back(r);
	endfunction

	function void check_result(window_result_t got);
		window_result_t exp;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result beat %h", got);
			return;
		end
		exp = pending.pop_front();
		if (got !== exp) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"mismatch: exp avg %h slope %h v %b s %b n %0d",
					" / got avg %h slope %h v %b s %b n %0d"},
					exp.average_value, exp.average_slope, exp.slope_valid,
					exp.slope_saturated, exp.sample_count, got.average_value,
					got.average_slope, got.slope_valid, got.slope_saturated,
					got.sample_count);
		end
	endfunction
endclass

module tb_windowed_average_and_slope;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_BEATS = 1080;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] sample_value = '0;
	logic [31:0]        time_ms = '0;
	logic               restart = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] average_value;
	logic signed [31:0] average_slope;
	logic               slope_valid;
	logic               slope_saturated;
	logic [3:0]         sample_count;

	window_scoreboard   board = new();
	int                 send_idle_pct = 0;
	int                 recv_idle_pct = 0;
	int                 quiet_cycles = 0;
	logic [31:0]        clock_ms = '0;

	always #5 clk = ~clk;

	windowed_average_and_slope i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_value(sample_value), .time_ms(time_ms), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.average_value(average_value), .average_slope(average_slope),
		.slope_valid(slope_valid), .slope_saturated(slope_saturated),
		.sample_count(sample_count)
	);

	// result side: check on rising edge, stall decided at falling edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result({average_value, average_slope, slope_valid,
				slope_saturated, sample_count});
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog on cycles with no accepted beat on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// send one sample beat and wait for it to be taken; valid is dropped by
	// the next idle cycle or by drain
	task automatic send_sample(logic signed [31:0] value, logic [31:0] now, logic rst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_value <= value;
		time_ms <= now;
		restart <= rst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_sample(value, now, rst);
		@(negedge clk);
	endtask

	// random sample: mostly small timestamp steps, sometimes wraps or zero gaps
	task automatic send_random();
		logic signed [31:0] value;
		logic [31:0] step;
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			step = 0;
		else if (pick < 80)
			step = $urandom_range(1, 2000);
		else if (pick < 90)
			step = $urandom_range(1, 3);
		else
			step = $urandom;
		clock_ms = clock_ms + step;
		pick = $urandom_range(99);
		if (pick < 50)
			value = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
		else if (pick < 60)
			value = ($urandom_range(1)) ? was_pkg::Q_MAX : was_pkg::Q_MIN;
		else
			value = $urandom;
		send_sample(value, clock_ms, $urandom_range(99) < 6);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	initial begin
		int phase_beats;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, zero gaps, a wrapping timestamp, restarts
		send_sample(32'sh0001_0000, 32'd0, 1'b0);
		send_sample(was_pkg::Q_MAX, 32'd0, 1'b0);
		send_sample(was_pkg::Q_MIN, 32'd1, 1'b0);
		send_sample(was_pkg::Q_MAX, 32'd2, 1'b0);
		send_sample(was_pkg::Q_MAX, 32'd2, 1'b0);
		send_sample(32'sh0000_0000, 32'd2, 1'b0);
		send_sample(-32'sh0002_8000, 32'hFFFF_FFF0, 1'b0);
		send_sample(32'sh0003_0000, 32'h0000_0010, 1'b0);
		send_sample(32'sh0003_0001, 32'hFFFF_FFFF, 1'b0);
		send_sample(-32'sd1, 32'h8000_0000, 1'b0);
		send_sample(32'sd1, 32'h8000_03E8, 1'b0);
		send_sample(32'sh1234_5678, 32'h5555_5555, 1'b1);
		send_sample(-32'sh1234_5678, 32'hAAAA_AAAA, 1'b0);
		send_sample(was_pkg::Q_MIN, 32'hFFFF_FFFF, 1'b1);
		send_sample(was_pkg::Q_MAX, 32'h0000_0000, 1'b0);
		send_sample(32'sd7, 32'd100, 1'b1);
		send_sample(32'sd7, 32'd100, 1'b1);
		drain();

		// three idle profiles over the random part
		phase_beats = RANDOM_BEATS / 3;
		send_idle_pct = 35;
		recv_idle_pct = 76;
		repeat (phase_beats) send_random();
		send_idle_pct = 76;
		recv_idle_pct = 35;
		repeat (phase_beats) send_random();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (RANDOM_BEATS - 2 * phase_beats) send_random();

		drain();
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
